/* src/tracker_pattern_repacker_core_assert.svh */
// Assertion macros used by the emitter. They use the clk and rst_n of the enclosing module.
`ifndef TRACKER_PATTERN_REPACKER_CORE_ASSERT_SVH
`define TRACKER_PATTERN_REPACKER_CORE_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted.
`define TPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define TPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tpr_pkg.sv */
`timescale 1ns / 1ps
package tpr_pkg;

  localparam int KEPT_CHANNELS_DEF = 4;
  localparam int ROWS_DEF          = 64;

  localparam logic [7:0] NOTE_NONE  = 8'hFF;
  localparam logic [7:0] VOL_NONE   = 8'hFF;
  localparam logic [7:0] VOL_MAX    = 8'd64;
  localparam logic [7:0] ROW_END_BY = 8'h00;

  // Bits needed to index n entries (at least one).
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       pattern_start;
  } tpr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [5:0] row_index;
    logic       row_end;
  } tpr_out_t;

  typedef struct packed {
    logic [7:0] note;
    logic [7:0] ins;
    logic [7:0] vol;
    logic [7:0] eff;
    logic [7:0] prm;
  } tpr_cell_t;

  localparam tpr_cell_t CELL_EMPTY = '{note: NOTE_NONE, ins: 8'h00, vol: VOL_NONE,
                                       eff: 8'h00, prm: 8'h00};

  typedef struct packed {
    logic eff;
    logic vol;
    logic note;
  } tpr_flags_t;

  // Write of one finished cell into the cell store.
  typedef struct packed {
    logic      we;
    logic [4:0] addr;
    tpr_cell_t entry;
  } tpr_wr_t;

  typedef enum logic [2:0] {
    PH_MASK,
    PH_NOTE,
    PH_INS,
    PH_VOL,
    PH_EFF,
    PH_PRM
  } tpr_phase_t;

  typedef enum logic [2:0] {
    ES_IDLE,
    ES_READ,
    ES_LOAD,
    ES_EMIT,
    ES_TERM
  } tpr_emit_state_t;

endpackage

/* src/tpr_ram.sv */
`timescale 1ns / 1ps
module tpr_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = tpr_pkg::KEPT_CHANNELS_DEF
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [tpr_pkg::idx_bits(DEPTH)-1:0]     waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [tpr_pkg::idx_bits(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]                        rdata
);
  import tpr_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tpr_cell_store.sv */
`timescale 1ns / 1ps
module tpr_cell_store #(
  parameter int KEPT_CHANNELS = tpr_pkg::KEPT_CHANNELS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  tpr_pkg::tpr_wr_t                           wr,
  input  logic                                       clear,
  input  logic [tpr_pkg::idx_bits(KEPT_CHANNELS)-1:0] rd_addr,
  output tpr_pkg::tpr_cell_t                         rd_cell
);
  import tpr_pkg::*;

  localparam int CHW = idx_bits(KEPT_CHANNELS);
  localparam int CW  = $bits(tpr_cell_t);

  logic [KEPT_CHANNELS-1:0] valid_r, valid_nxt;
  logic                     rd_valid_r;
  logic [CW-1:0]            rdata;

  tpr_ram #(.WIDTH(CW), .DEPTH(KEPT_CHANNELS)) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr[CHW-1:0]),
    .wdata (wr.entry),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // A clear and a commit in the same cycle leave the committed entry valid.
  always_comb begin
    valid_nxt = clear ? '0 : valid_r;
    if (wr.we) begin
      valid_nxt[wr.addr[CHW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_cell = rd_valid_r ? tpr_cell_t'(rdata) : CELL_EMPTY;

endmodule

/* src/tpr_parser.sv */
`timescale 1ns / 1ps
module tpr_parser #(
  parameter int KEPT_CHANNELS = tpr_pkg::KEPT_CHANNELS_DEF,
  parameter int ROWS          = tpr_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  tpr_pkg::tpr_in_t             in_item,
  input  logic                         row_done,
  output tpr_pkg::tpr_wr_t             wr,
  output logic                         clear,
  output logic                         row_go,
  output logic [$clog2(ROWS+1)-1:0]    row_cnt
);
  import tpr_pkg::*;

  localparam int RCW = $clog2(ROWS + 1);

  tpr_phase_t       phase_r, phase_nxt, cur_phase;
  logic [4:0]       chan_r, chan_nxt;
  tpr_flags_t       flags_r, flags_nxt;
  tpr_cell_t        cell_r, cell_nxt;
  logic [RCW-1:0]   row_cnt_r, row_cnt_nxt, cur_rows;
  logic             start, active, commit;
  logic [7:0]       b;

  // A pattern start resets the parse state first and then is taken as a mask.
  always_comb begin
    b         = in_item.packed_byte;
    start     = accept && in_item.pattern_start;
    cur_phase = start ? PH_MASK : phase_r;
    cur_rows  = start ? '0 : row_cnt_r;
    active    = accept && (cur_rows < RCW'(ROWS));
  end

  always_comb begin
    phase_nxt = phase_r;
    chan_nxt  = chan_r;
    flags_nxt = flags_r;
    cell_nxt  = cell_r;
    commit    = 1'b0;
    if (start) begin
      phase_nxt = PH_MASK;
      chan_nxt  = '0;
      flags_nxt = '0;
      cell_nxt  = CELL_EMPTY;
    end
    if (active) begin
      case (cur_phase)
        PH_MASK: begin
          if (b != ROW_END_BY) begin
            chan_nxt  = b[4:0];
            flags_nxt = '{eff: b[7], vol: b[6], note: b[5]};
            cell_nxt  = CELL_EMPTY;
            if (flags_nxt.note) begin
              phase_nxt = PH_NOTE;
            end else if (flags_nxt.vol) begin
              phase_nxt = PH_VOL;
            end else if (flags_nxt.eff) begin
              phase_nxt = PH_EFF;
            end else begin
              commit = 1'b1;
            end
          end
        end
        PH_NOTE: begin
          cell_nxt.note = b;
          phase_nxt     = PH_INS;
        end
        PH_INS: begin
          cell_nxt.ins = b;
          if (flags_r.vol) begin
            phase_nxt = PH_VOL;
          end else if (flags_r.eff) begin
            phase_nxt = PH_EFF;
          end else begin
            phase_nxt = PH_MASK;
            commit    = 1'b1;
          end
        end
        PH_VOL: begin
          cell_nxt.vol = b;
          if (flags_r.eff) begin
            phase_nxt = PH_EFF;
          end else begin
            phase_nxt = PH_MASK;
            commit    = 1'b1;
          end
        end
        PH_EFF: begin
          cell_nxt.eff = b;
          phase_nxt    = PH_PRM;
        end
        PH_PRM: begin
          cell_nxt.prm = b;
          phase_nxt    = PH_MASK;
          commit       = 1'b1;
        end
        default: begin
          phase_nxt = PH_MASK;
        end
      endcase
    end
    row_cnt_nxt = row_done ? row_cnt_r + 1'b1 : cur_rows;
  end

  // Cells of channels beyond the kept ones are parsed and then dropped.
  always_comb begin
    wr.we    = commit && ({1'b0, chan_nxt} < 6'(KEPT_CHANNELS));
    wr.addr  = chan_nxt;
    wr.entry = cell_nxt;
    clear    = start;
    row_go   = active && (cur_phase == PH_MASK) && (b == ROW_END_BY);
    row_cnt  = row_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MASK;
      chan_r    <= '0;
      flags_r   <= '0;
      row_cnt_r <= '0;
      cell_r    <= CELL_EMPTY;
    end else begin
      phase_r   <= phase_nxt;
      chan_r    <= chan_nxt;
      flags_r   <= flags_nxt;
      row_cnt_r <= row_cnt_nxt;
      cell_r    <= cell_nxt;
    end
  end

endmodule

/* src/tpr_emitter.sv */
`timescale 1ns / 1ps
`include "tracker_pattern_repacker_core_assert.svh"
module tpr_emitter #(
  parameter int KEPT_CHANNELS = tpr_pkg::KEPT_CHANNELS_DEF,
  parameter int ROWS          = tpr_pkg::ROWS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       row_go,
  input  logic [$clog2(ROWS+1)-1:0]                  row_cnt,
  input  tpr_pkg::tpr_cell_t                         rd_cell,
  output logic [tpr_pkg::idx_bits(KEPT_CHANNELS)-1:0] rd_addr,
  output logic                                       row_done,
  output logic                                       in_stall,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output tpr_pkg::tpr_out_t                          out_data
);
  import tpr_pkg::*;

  localparam int CHW = idx_bits(KEPT_CHANNELS);

  tpr_emit_state_t state_r, state_nxt;
  logic [CHW-1:0]  ch_r, ch_nxt;
  // Bytes still to send for the current cell: flag, note, ins, vol, eff, prm.
  logic [5:0]      mask_r, mask_nxt;
  tpr_cell_t       cell_r, cell_nxt;
  tpr_out_t        out_r;
  logic            out_valid_r, out_valid_nxt;
  logic            can_load, load, last_ch, hn, hv, he;
  logic [7:0]      sel_byte;

  always_comb begin
    can_load = !out_valid_r || !out_stall;
    last_ch  = (ch_r == CHW'(KEPT_CHANNELS - 1));
    hn       = (rd_cell.note != NOTE_NONE) || (rd_cell.ins != 8'h00);
    hv       = (rd_cell.vol <= VOL_MAX);
    he       = (rd_cell.eff != 8'h00) || (rd_cell.prm != 8'h00);
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    mask_nxt  = mask_r;
    cell_nxt  = cell_r;
    case (state_r)
      ES_IDLE: begin
        if (row_go) begin
          state_nxt = ES_READ;
          ch_nxt    = '0;
        end
      end
      ES_READ: begin
        state_nxt = ES_LOAD;
      end
      ES_LOAD: begin
        cell_nxt = rd_cell;
        mask_nxt = {he, he, hv, hn, hn, hn | hv | he};
        if (hn || hv || he) begin
          state_nxt = ES_EMIT;
        end else if (last_ch) begin
          state_nxt = ES_TERM;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ES_READ;
        end
      end
      ES_EMIT: begin
        if (can_load) begin
          mask_nxt = mask_r & (mask_r - 6'd1);
          if (mask_nxt == 6'd0) begin
            if (last_ch) begin
              state_nxt = ES_TERM;
            end else begin
              ch_nxt    = ch_r + 1'b1;
              state_nxt = ES_READ;
            end
          end
        end
      end
      ES_TERM: begin
        if (can_load) begin
          state_nxt = ES_IDLE;
        end
      end
      default: begin
        state_nxt = ES_IDLE;
      end
    endcase
  end

  // The flag byte goes first, while every field bit of the mask is still set.
  always_comb begin
    load     = ((state_r == ES_EMIT) || (state_r == ES_TERM)) && can_load;
    row_done = (state_r == ES_TERM) && can_load;
    in_stall = (state_r != ES_IDLE);
    rd_addr  = ch_r;
    if (state_r == ES_TERM) begin
      sel_byte = ROW_END_BY;
    end else if (mask_r[0]) begin
      sel_byte = {mask_r[4], mask_r[3], mask_r[1], 5'(ch_r)};
    end else if (mask_r[1]) begin
      sel_byte = cell_r.note;
    end else if (mask_r[2]) begin
      sel_byte = cell_r.ins;
    end else if (mask_r[3]) begin
      sel_byte = cell_r.vol;
    end else if (mask_r[4]) begin
      sel_byte = cell_r.eff;
    end else begin
      sel_byte = cell_r.prm;
    end
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ES_IDLE;
      ch_r        <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (load) begin
      out_r <= '{out_byte: sel_byte, row_index: 6'(row_cnt),
                 row_end: (state_r == ES_TERM)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TPR_ASSERT_NOW(a_go_only_idle, row_go, state_r == ES_IDLE, "row end while emitting")
  `TPR_ASSERT_NOW(a_emit_has_bytes, state_r == ES_EMIT, mask_r != 6'd0, "emit with empty mask")
  `TPR_ASSERT_NEXT(a_term_to_idle, row_done, (state_r == ES_IDLE) && out_valid_r && out_r.row_end,
                   "terminator not loaded")

endmodule

/* src/tracker_pattern_repacker_core.sv */
`timescale 1ns / 1ps
// Input bytes are taken one per cycle while a row is being parsed.
// A row-end byte stalls the input while the emitter takes each kept channel through a read
// and a load state and sends its cell bytes and the row terminator, and during any output stall.
// The first result of a row is registered after the read, load and emit states, with another
// read and load for each empty channel ahead of it. Synchronous reset clears the parse state,
// row counter and valid bits; the cell memory itself needs no clearing pass.
module tracker_pattern_repacker_core #(
  parameter int KEPT_CHANNELS = tpr_pkg::KEPT_CHANNELS_DEF,
  parameter int ROWS          = tpr_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tpr_pkg::tpr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tpr_pkg::tpr_out_t out_data
);
  import tpr_pkg::*;

  localparam int CHW = idx_bits(KEPT_CHANNELS);
  localparam int RCW = $clog2(ROWS + 1);

  tpr_wr_t        wr;
  tpr_cell_t      rd_cell;
  logic [CHW-1:0] rd_addr;
  logic [RCW-1:0] row_cnt;
  logic           accept, clear, row_go, row_done;

  assign accept = in_valid && !in_stall;

  tpr_parser #(.KEPT_CHANNELS(KEPT_CHANNELS), .ROWS(ROWS)) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_data),
    .row_done (row_done),
    .wr       (wr),
    .clear    (clear),
    .row_go   (row_go),
    .row_cnt  (row_cnt)
  );

  tpr_cell_store #(.KEPT_CHANNELS(KEPT_CHANNELS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .clear   (clear || row_done),
    .rd_addr (rd_addr),
    .rd_cell (rd_cell)
  );

  tpr_emitter #(.KEPT_CHANNELS(KEPT_CHANNELS), .ROWS(ROWS)) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_go    (row_go),
    .row_cnt   (row_cnt),
    .rd_cell   (rd_cell),
    .rd_addr   (rd_addr),
    .row_done  (row_done),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
